>>> design/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a named clock with an active-low reset
`define ARE_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the default clock and reset names
`define ARE_ASSERT(name, prop, msg) \
  `ARE_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

>>> design/are_pkg.sv
// Package for the arithmetic run encoder: defaults, item and result types.
// No dependencies.
package are_pkg;

  // Default width of the block counter
  localparam int unsigned CountBitsDef = 32;

  // Input request as held in the front queue
  typedef struct packed {
    logic [63:0] value;
    logic        eos;
  } item_t;

  // Emitted block as held in the output queue
  typedef struct packed {
    logic [63:0] base_value;
    logic [63:0] step;
    logic [31:0] extra_count;
    logic        fin;
  } result_t;

endpackage

>>> design/are_front.sv
// Front of the arithmetic run encoder: two-entry input queue.
// Depends on are_pkg.
module are_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  are_pkg::item_t in_item_i,
  output logic           head_valid_o,
  output are_pkg::item_t head_o,
  input  logic           pop_i
);
  import are_pkg::*;

  item_t       mem_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  // Accept while a slot is free
  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the request payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_item_i;
    end
  end

endmodule

>>> design/are_back.sv
// Back of the arithmetic run encoder: block state, classification and
// four-entry output queue. Depends on are_pkg.
module are_back #(
  parameter int unsigned COUNT_BITS = are_pkg::CountBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  are_pkg::item_t   head_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output are_pkg::result_t res_o
);
  import are_pkg::*;

  localparam int unsigned CntW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  // Open block state
  logic            open_q, open_d, open_n;
  logic [63:0]     base_q, base_d, base_n;
  logic [63:0]     step_q, step_d, step_n;
  logic [CntW-1:0] extra_q, extra_d, extra_n;
  logic [63:0]     last_q, last_d, last_n;

  // Output queue
  result_t         ofifo_q [4];
  logic [1:0]      owptr_q, owptr_d;
  logic [1:0]      orptr_q, orptr_d;
  logic [2:0]      ocnt_q, ocnt_d;

  logic            hit, brk, deq, we0, we1;
  logic [1:0]      nwr;
  result_t         res_a, res_b, wd0;

  // Classify the head request against the open block
  always_comb begin
    hit    = open_q && (head_i.value == last_q + step_q) && !(&extra_q);
    brk    = open_q && !hit && (extra_q != '0);
    open_n = 1'b1;
    base_n = base_q;
    step_n = step_q;
    extra_n = extra_q;
    last_n = head_i.value;
    if (!open_q || brk) begin
      base_n  = head_i.value;
      step_n  = '0;
      extra_n = '0;
    end else if (hit) begin
      extra_n = extra_q + CntW'(1);
    end else begin
      step_n  = head_i.value - base_q;
      extra_n = CntW'(1);
    end
  end

  // Form the closed block and the flushed block
  always_comb begin
    res_a = '{base_value: base_q, step: step_q, extra_count: 32'(extra_q),
              fin: !head_i.eos};
    res_b = '{base_value: base_n, step: step_n, extra_count: 32'(extra_n),
              fin: 1'b1};
  end

  // Take a request only when two output slots are free
  assign pop_o = head_valid_i && (ocnt_q <= 3'd2);
  assign we0   = pop_o && (brk || head_i.eos);
  assign we1   = pop_o && brk && head_i.eos;
  assign wd0   = brk ? res_a : res_b;
  assign nwr   = 2'(we0) + 2'(we1);

  assign res_valid_o = (ocnt_q != 3'd0);
  assign res_o       = ofifo_q[orptr_q];
  assign deq         = res_valid_o && res_ready_i;

  // Update block state; drop the block after the end of stream
  always_comb begin
    open_d  = open_q;
    base_d  = base_q;
    step_d  = step_q;
    extra_d = extra_q;
    last_d  = last_q;
    if (pop_o) begin
      if (head_i.eos) begin
        open_d  = 1'b0;
        base_d  = '0;
        step_d  = '0;
        extra_d = '0;
        last_d  = '0;
      end else begin
        open_d  = open_n;
        base_d  = base_n;
        step_d  = step_n;
        extra_d = extra_n;
        last_d  = last_n;
      end
    end
    owptr_d = owptr_q + nwr;
    orptr_d = orptr_q + 2'(deq);
    ocnt_d  = ocnt_q + 3'(nwr) - 3'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      base_q  <= '0;
      step_q  <= '0;
      extra_q <= '0;
      last_q  <= '0;
      owptr_q <= 2'd0;
      orptr_q <= 2'd0;
      ocnt_q  <= 3'd0;
    end else begin
      open_q  <= open_d;
      base_q  <= base_d;
      step_q  <= step_d;
      extra_q <= extra_d;
      last_q  <= last_d;
      owptr_q <= owptr_d;
      orptr_q <= orptr_d;
      ocnt_q  <= ocnt_d;
    end
  end

  // Write up to two results per request
  always_ff @(posedge clk_i) begin
    if (we0) begin
      ofifo_q[owptr_q] <= wd0;
    end
    if (we1) begin
      ofifo_q[owptr_q + 2'd1] <= res_b;
    end
  end

endmodule

>>> design/arithmetic_run_encoder.sv
// Top level of the arithmetic run encoder: input queue feeding the block
// engine with its output queue. Depends on are_pkg, are_front, are_back.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   value_i, end_of_stream_i
//   out      output     out_valid_o / out_ready_i base_value_o, step_o,
//                                                 extra_count_o, final_block_o
//
// One request per cycle sustained while results are taken, set by the single
// compare-and-add on the running last value in the back end. A request waits
// in the input queue and its result in the output queue before it is offered.
// Reset empties both queues and leaves no block open.
// The back end takes a request only while its four-entry output queue has two
// free slots, so an output stall backs up into the two-entry input queue.
module arithmetic_run_encoder #(
  parameter int unsigned COUNT_BITS = are_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] base_value_o,
  output logic [63:0] step_o,
  output logic [31:0] extra_count_o,
  output logic        final_block_o
);
  import are_pkg::*;

  item_t   in_item, head;
  logic    head_valid, pop;
  result_t res;

  assign in_item = '{value: value_i, eos: end_of_stream_i};

  // Buffer incoming requests
  are_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Build blocks and queue results
  are_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign base_value_o  = res.base_value;
  assign step_o        = res.step;
  assign extra_count_o = res.extra_count;
  assign final_block_o = res.fin;

endmodule

>>> design/are_checker.sv
// Port-level checks for the arithmetic run encoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module are_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [63:0] value_i,
  input logic        end_of_stream_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] base_value_o,
  input logic [63:0] step_o,
  input logic [31:0] extra_count_o,
  input logic        final_block_o
);

  // Hold a result until taken
  `ARE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // A block closed by a break always holds more than its base
  `ARE_ASSERT(a_break_count, out_valid_o && !final_block_o |-> extra_count_o != 32'd0, "empty break")

  // The flushed block follows a break result at once
  `ARE_ASSERT(a_break_pair, out_valid_o && out_ready_i && !final_block_o |=> out_valid_o && final_block_o, "flush missing")

  // A nonzero step needs at least one value after the base
  `ARE_ASSERT(a_step_count, out_valid_o && step_o != 64'd0 |-> extra_count_o != 32'd0, "step without count")

endmodule

bind arithmetic_run_encoder are_checker u_are_checker (.*);

>>> bench/arithmetic_run_encoder_tb.sv
// Testbench for the arithmetic run encoder: streams values through the request
// channel, predicts the emitted blocks and checks each one in order.
// Depends on are_pkg and arithmetic_run_encoder.
module arithmetic_run_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import are_pkg::*;

  // Narrow counter so that a full block turns up within a short run
  localparam int unsigned CountBits = 8;
  localparam logic [31:0] ExtraMax  = (CountBits >= 32) ? 32'hFFFF_FFFF :
                                      ((32'd1 << CountBits) - 32'd1);

  localparam int     RandomItems = 1000;
  localparam int     DrainCycles = 5000;
  localparam int     TailCycles  = 20;
  localparam longint TimeoutNs   = 8_000_000;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TopBit  = 64'h8000_0000_0000_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        req_valid;
  logic        req_ready;
  logic [63:0] req_value;
  logic        req_eos;
  logic        blk_valid;
  logic        blk_ready;
  logic [63:0] blk_base;
  logic [63:0] blk_step;
  logic [31:0] blk_extra;
  logic        blk_fin;

  // Encoder state as seen by the predictor
  logic        run_open;
  logic [63:0] run_base;
  logic [63:0] run_step;
  logic [31:0] run_extra;
  logic [63:0] run_last;

  result_t predicted_q[$];
  result_t expected_blocks[$];
  int      mismatch_cnt = 0;
  bit      sender_calm  = 1'b0;

  // One directed request, with its blocks typed in where they are obvious
  typedef struct {
    logic [63:0] value;
    logic        eos;
    bit          typed;
    int          n_typed;
    result_t     blk;
  } dir_row_t;

  dir_row_t directed_rows[$];

  arithmetic_run_encoder #(
    .COUNT_BITS(CountBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_ready_o     (req_ready),
    .value_i        (req_value),
    .end_of_stream_i(req_eos),
    .out_valid_o    (blk_valid),
    .out_ready_i    (blk_ready),
    .base_value_o   (blk_base),
    .step_o         (blk_step),
    .extra_count_o  (blk_extra),
    .final_block_o  (blk_fin)
  );

  always #2 clk_i = ~clk_i;

  function automatic result_t make_result(logic [63:0] base, logic [63:0] step,
                                          logic [31:0] extra, logic fin);
    result_t r;
    r.base_value  = base;
    r.step        = step;
    r.extra_count = extra;
    r.fin         = fin;
    return r;
  endfunction

  function automatic void clear_run();
    run_open  = 1'b0;
    run_base  = '0;
    run_step  = '0;
    run_extra = '0;
    run_last  = '0;
  endfunction

  function automatic void open_run(logic [63:0] v);
    run_open  = 1'b1;
    run_base  = v;
    run_step  = '0;
    run_extra = '0;
    run_last  = v;
  endfunction

  // Fold one value into the open run; leave emitted blocks in predicted_q
  function automatic void encode_value(logic [63:0] v, logic eos);
    logic [63:0] next_val;
    predicted_q.delete();
    next_val = run_last + run_step;
    if (!run_open) begin
      open_run(v);
    end else if (v == next_val && run_extra < ExtraMax) begin
      run_extra = run_extra + 32'd1;
      run_last  = v;
    end else if (run_extra == 32'd0) begin
      run_step  = v - run_base;
      run_extra = 32'd1;
      run_last  = v;
    end else begin
      predicted_q.insert(predicted_q.size(),
                         make_result(run_base, run_step, run_extra, 1'b0));
      open_run(v);
    end
    // Flush on end of stream, else mark the last block of this request
    if (eos) begin
      predicted_q.insert(predicted_q.size(),
                         make_result(run_base, run_step, run_extra, 1'b1));
      clear_run();
    end else if (predicted_q.size() > 0) begin
      predicted_q[predicted_q.size() - 1].fin = 1'b1;
    end
  endfunction

  function automatic void add_row(logic [63:0] v, logic eos, bit typed, int n_typed,
                                  result_t blk);
    dir_row_t row;
    row.value   = v;
    row.eos     = eos;
    row.typed   = typed;
    row.n_typed = n_typed;
    row.blk     = blk;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AllOnes;
      2:       return TopBit;
      3:       return AllOnes - 64'($urandom_range(0, 20));
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [63:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 64'd1;
      3:       return AllOnes;
      4:       return 64'($urandom_range(2, 16));
      5:       return -64'($urandom_range(2, 16));
      6:       return TopBit;
      default: return rand_word();
    endcase
  endfunction

  // Present one request at a falling edge and hold it until accepted
  task automatic send_request(logic [63:0] v, logic eos);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid <= 1'b1;
    req_value <= v;
    req_eos   <= eos;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
  endtask

  task automatic drop_request();
    @(negedge clk_i);
    req_valid <= 1'b0;
  endtask

  task automatic send_and_predict(logic [63:0] v, logic eos);
    send_request(v, eos);
    encode_value(v, eos);
    foreach (predicted_q[i]) expected_blocks.insert(expected_blocks.size(), predicted_q[i]);
  endtask

  // Stall the result channel: short stalls, a few long ones, open stretches
  initial begin : drive_ready
    int   r;
    int   span;
    logic level;
    blk_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        level = 1'b1;
        span  = $urandom_range(40, 200);
      end else if (r < 55) begin
        level = 1'b1;
        span  = $urandom_range(1, 6);
      end else if (r < 90) begin
        level = 1'b0;
        span  = $urandom_range(1, 3);
      end else if (r < 97) begin
        level = 1'b0;
        span  = $urandom_range(4, 12);
      end else begin
        level = 1'b0;
        span  = $urandom_range(20, 60);
      end
      @(negedge clk_i);
      blk_ready <= level;
      repeat (span - 1) @(negedge clk_i);
    end
  end

  // Compare every accepted block with the oldest expected one
  always @(posedge clk_i) begin : check_blocks
    result_t want;
    if (rst_ni && blk_valid && blk_ready) begin
      if (expected_blocks.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected block: base %h step %h extra %0d fin %b",
                   blk_base, blk_step, blk_extra, blk_fin);
      end else begin
        want = expected_blocks.pop_front();
        if (blk_base !== want.base_value || blk_step !== want.step ||
            blk_extra !== want.extra_count || blk_fin !== want.fin) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("block mismatch: base %h/%h step %h/%h extra %0d/%0d fin %b/%b",
                     want.base_value, blk_base, want.step, blk_step,
                     want.extra_count, blk_extra, want.fin, blk_fin);
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0] base;
    logic [63:0] step;
    logic [63:0] v;
    logic        eos;
    int          len;
    int          seq_idx;
    int          sent;
    int          drain;
    bit          broken;
    bit          closing;

    req_valid = 1'b0;
    req_value = '0;
    req_eos   = 1'b0;
    rst_ni    = 1'b0;
    clear_run();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, wrapping steps, step fixing, a break with a flush on the same request
    add_row('0, 1'b1, 1'b1, 1, make_result('0, '0, 32'd0, 1'b1));
    add_row(AllOnes, 1'b1, 1'b1, 1, make_result(AllOnes, '0, 32'd0, 1'b1));
    add_row(64'd5, 1'b0, 1'b1, 0, '0);
    add_row(64'd5, 1'b0, 1'b1, 0, '0);
    add_row(64'd5, 1'b1, 1'b1, 1, make_result(64'd5, '0, 32'd2, 1'b1));
    add_row(64'd10, 1'b0, 1'b0, 0, '0);
    add_row(64'd3, 1'b0, 1'b0, 0, '0);
    add_row(AllOnes - 64'd3, 1'b0, 1'b0, 0, '0);
    add_row(64'd100, 1'b1, 1'b0, 0, '0);
    add_row('0, 1'b0, 1'b0, 0, '0);
    add_row(AllOnes, 1'b0, 1'b0, 0, '0);
    add_row(AllOnes - 64'd1, 1'b0, 1'b0, 0, '0);
    add_row(64'd7, 1'b0, 1'b0, 0, '0);
    add_row(64'd8, 1'b1, 1'b0, 0, '0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 0, '0);
    add_row(64'h5555_5555_5555_5555, 1'b0, 1'b0, 0, '0);
    add_row('0, 1'b0, 1'b0, 0, '0);
    add_row(64'hAAAA_AAAA_AAAA_AAAB, 1'b0, 1'b0, 0, '0);
    add_row(TopBit, 1'b0, 1'b0, 0, '0);
    add_row(TopBit, 1'b1, 1'b0, 0, '0);

    // Walk the directed rows
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].value, directed_rows[i].eos);
      encode_value(directed_rows[i].value, directed_rows[i].eos);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].n_typed > 0)
          expected_blocks.insert(expected_blocks.size(), directed_rows[i].blk);
      end else begin
        foreach (predicted_q[j]) expected_blocks.insert(expected_blocks.size(), predicted_q[j]);
      end
    end

    // Hold off until every block so far has come out
    drop_request();
    while (expected_blocks.size() != 0) @(posedge clk_i);

    // Random progressions, mostly well formed, some broken, some noise
    sent    = 0;
    seq_idx = 0;
    while (sent < RandomItems) begin
      sender_calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 99) < 12) begin
        send_and_predict(rand_word(), $urandom_range(0, 7) == 0);
        sent++;
      end else begin
        base = pick_base();
        step = pick_step();
        if (seq_idx == 5 || $urandom_range(0, 59) == 0)
          len = int'(ExtraMax) - 1 + $urandom_range(0, 4);
        else if ($urandom_range(0, 99) < 75)
          len = $urandom_range(1, 8);
        else
          len = $urandom_range(9, 40);
        broken  = ($urandom_range(0, 4) == 0);
        closing = ($urandom_range(0, 2) == 0);
        v = base;
        for (int i = 0; i < len; i++) begin
          eos = (i == len - 1 && closing && !broken) || ($urandom_range(0, 63) == 0);
          send_and_predict(v, eos);
          v = v + step;
          sent++;
        end
        if (broken) begin
          send_and_predict(rand_word(), $urandom_range(0, 3) == 0);
          sent++;
        end
      end
      seq_idx++;
      if (seq_idx == 40) begin
        drop_request();
        while (expected_blocks.size() != 0) @(posedge clk_i);
      end
    end

    // Drain what is still in flight
    drop_request();
    drain = 0;
    while (expected_blocks.size() != 0 && drain < DrainCycles) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_blocks.size() != 0) begin
      mismatch_cnt++;
      $display("%0d expected blocks never came out", expected_blocks.size());
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(TimeoutNs);
    $display("FAIL");
    $finish;
  end

endmodule
